// ----- hw/rtl/stb_pkg.sv -----
// Shared types and constants for the software timer bank.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stb_pkg;
   localparam int NumTimers = 16;
   localparam int SlotBits = $clog2(NumTimers);

   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_CREATE_ARMED = 3'd1;
   localparam logic [2:0] OP_REARM = 3'd2;
   localparam logic [2:0] OP_DISARM = 3'd3;
   localparam logic [2:0] OP_DELETE = 3'd4;
   localparam logic [2:0] OP_TICK = 3'd5;

   localparam logic [1:0] KIND_REPLY = 2'd0;
   localparam logic [1:0] KIND_FIRED = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   typedef struct packed {
      logic [2:0] opcode;
      logic [31:0] timeout_ticks;
      logic periodic;
      logic [31:0] target_handle;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [31:0] handle;
      logic last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;       // capture request
      logic clr_scan;       // restart slot walk
      logic step_scan;      // advance slot index
      logic seed_step;      // advance handle candidate
      logic seed_clr_hit;   // clear candidate-taken flag
      logic do_create;      // write created slot
      logic do_target;      // apply rearm/disarm/delete at found slot
      logic do_tick;        // update current slot for tick
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] opcode;
      logic scan_last;      // index at final slot
      logic tout_zero;
      logic have_free;
      logic cand_taken;     // candidate handle found in a used slot
      logic slot_fires;     // current slot fires on this tick
   } sts_type;
endpackage
`default_nettype wire

// ----- hw/rtl/stb_if.sv -----
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface stb_if #(type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/stb_datapath.sv -----
// Slot table, handle seed and scan index for the timer bank.
// Depends on stb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stb_datapath import stb_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire req_type req_data,
   input wire cmd_type cmd,
   output sts_type sts,
   output logic [31:0] cur_handle,
   output logic [31:0] new_handle
);
   logic [NumTimers-1:0] used_ff, used_in, active_ff, active_in;
   logic [NumTimers-1:0] periodic_ff;
   logic [31:0] handle_ff [NumTimers];
   logic [31:0] reload_ff [NumTimers];
   logic [31:0] count_ff [NumTimers];
   logic [31:0] seed_ff, seed_in;
   logic [SlotBits-1:0] idx_ff, idx_in;
   logic hit_ff, hit_in;
   logic found_ff, found_in;
   logic [SlotBits-1:0] found_idx_ff, found_idx_in;
   logic [SlotBits-1:0] free_idx_ff, free_idx_in;
   logic free_ok_ff, free_ok_in;
   req_type req_ff;
   logic [31:0] cand;
   logic idx_match;

   assign cand = (seed_ff == 32'hFFFF_FFFF) ? 32'd1 : seed_ff + 32'd1;
   assign idx_match = used_ff[idx_ff] && handle_ff[idx_ff] == req_ff.target_handle
                      && req_ff.target_handle != 32'd0;

   always_comb begin
      used_in = used_ff;
      active_in = active_ff;
      seed_in = seed_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      found_in = found_ff;
      found_idx_in = found_idx_ff;
      free_idx_in = free_idx_ff;
      free_ok_in = free_ok_ff;
      if (cmd.clr_scan) begin
         idx_in = '0;
      end else if (cmd.step_scan) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.load_req) begin
         found_in = 1'b0;
         free_ok_in = 1'b0;
         hit_in = 1'b0;
      end
      // scan side effects: lookup by target, lowest free, candidate taken
      if (!cmd.load_req) begin
         if (idx_match && !found_ff) begin
            found_in = 1'b1;
            found_idx_in = idx_ff;
         end
         if (!used_ff[idx_ff] && !free_ok_ff) begin
            free_ok_in = 1'b1;
            free_idx_in = idx_ff;
         end
         // seed holds the candidate under test during the candidate walk
         if (used_ff[idx_ff] && handle_ff[idx_ff] == seed_ff) begin
            hit_in = 1'b1;
         end
      end
      if (cmd.seed_clr_hit) begin
         hit_in = 1'b0;
      end
      if (cmd.seed_step) begin
         seed_in = cand;
      end
      if (cmd.do_create) begin
         used_in[free_idx_ff] = 1'b1;
         active_in[free_idx_ff] = (req_ff.opcode == OP_CREATE_ARMED);
      end
      if (cmd.do_target && found_ff) begin
         unique case (req_ff.opcode)
            OP_REARM: active_in[found_idx_ff] = 1'b1;
            OP_DISARM: active_in[found_idx_ff] = 1'b0;
            default: begin
               used_in[found_idx_ff] = 1'b0;
               active_in[found_idx_ff] = 1'b0;
            end
         endcase
      end
      if (cmd.do_tick && sts.slot_fires && !periodic_ff[idx_ff]) begin
         used_in[idx_ff] = 1'b0;
         active_in[idx_ff] = 1'b0;
      end
   end

   always_comb begin
      sts.opcode = req_ff.opcode;
      sts.scan_last = (idx_ff == SlotBits'(NumTimers - 1));
      sts.tout_zero = (req_ff.timeout_ticks == 32'd0);
      sts.have_free = free_ok_ff;
      sts.cand_taken = hit_ff;
      sts.slot_fires = used_ff[idx_ff] && active_ff[idx_ff] && count_ff[idx_ff] == 32'd0;
   end

   assign cur_handle = handle_ff[idx_ff];
   assign new_handle = seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         active_ff <= '0;
         seed_ff <= '0;
         idx_ff <= '0;
         hit_ff <= 1'b0;
         found_ff <= 1'b0;
         free_ok_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         active_ff <= active_in;
         seed_ff <= seed_in;
         idx_ff <= idx_in;
         hit_ff <= hit_in;
         found_ff <= found_in;
         free_ok_ff <= free_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      found_idx_ff <= found_idx_in;
      free_idx_ff <= free_idx_in;
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.do_create) begin
         handle_ff[free_idx_ff] <= seed_ff;
         reload_ff[free_idx_ff] <= req_ff.timeout_ticks;
         periodic_ff[free_idx_ff] <= req_ff.periodic;
         count_ff[free_idx_ff] <= (req_ff.opcode == OP_CREATE_ARMED)
                                  ? req_ff.timeout_ticks : 32'd0;
      end
      if (cmd.do_target && found_ff && req_ff.opcode == OP_REARM) begin
         count_ff[found_idx_ff] <= reload_ff[found_idx_ff];
      end
      if (cmd.do_tick && used_ff[idx_ff] && active_ff[idx_ff]) begin
         if (count_ff[idx_ff] == 32'd0) begin
            count_ff[idx_ff] <= reload_ff[idx_ff];
         end else begin
            count_ff[idx_ff] <= count_ff[idx_ff] - 32'd1;
         end
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/stb_control.sv -----
// Sequencer for the timer bank: walks slots, drives datapath, builds results.
// Depends on stb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stb_control import stb_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output rsp_type rsp_data,
   input wire sts_type sts,
   input wire logic [31:0] cur_handle,
   input wire logic [31:0] new_handle,
   output cmd_type cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;   // lookup / free search walk
   localparam logic [2:0] ST_SEED = 3'd2;   // candidate handle walk
   localparam logic [2:0] ST_DECIDE = 3'd3; // apply command
   localparam logic [2:0] ST_TICK = 3'd4;   // tick walk
   localparam logic [2:0] ST_OUT = 3'd5;    // wait for result drain

   logic [2:0] state_ff, state_in;
   logic [2:0] next_after_ff, next_after_in;
   logic out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic out_free;

   assign out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;
   assign req_ready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      state_in = state_ff;
      next_after_in = next_after_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in = out_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_req = 1'b1;
               cmd.clr_scan = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step_scan = 1'b1;
            if (sts.scan_last) begin
               if (sts.opcode == OP_TICK) begin
                  cmd.step_scan = 1'b0;
                  cmd.clr_scan = 1'b1;
                  state_in = ST_TICK;
               end else if (sts.opcode == OP_CREATE || sts.opcode == OP_CREATE_ARMED) begin
                  cmd.clr_scan = 1'b1;
                  cmd.step_scan = 1'b0;
                  cmd.seed_clr_hit = 1'b1;
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_SEED: begin
            // candidate = seed+1; walk slots checking whether it is taken
            cmd.step_scan = 1'b1;
            if (sts.scan_last) begin
               cmd.step_scan = 1'b0;
               cmd.clr_scan = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.opcode == OP_CREATE || sts.opcode == OP_CREATE_ARMED) begin
               cmd.clr_scan = 1'b1;
               if (sts.tout_zero || !sts.have_free) begin
                  if (out_free) begin
                     out_valid_in = 1'b1;
                     out_in = '{kind: KIND_REPLY, handle: 32'd0, last: 1'b1};
                     state_in = ST_IDLE;
                  end
               end else if (next_after_ff == ST_SEED && !sts.cand_taken) begin
                  // seed already points at the accepted candidate
                  if (out_free) begin
                     cmd.do_create = 1'b1;
                     out_valid_in = 1'b1;
                     out_in = '{kind: KIND_REPLY, handle: new_handle, last: 1'b1};
                     next_after_in = ST_IDLE;
                     state_in = ST_IDLE;
                  end
               end else begin
                  cmd.seed_step = 1'b1;
                  cmd.seed_clr_hit = 1'b1;
                  next_after_in = ST_SEED;
                  state_in = ST_SEED;
               end
            end else begin
               if (out_free) begin
                  cmd.do_target = (sts.opcode == OP_REARM || sts.opcode == OP_DISARM
                                   || sts.opcode == OP_DELETE);
                  out_valid_in = 1'b1;
                  out_in = '{kind: KIND_REPLY, handle: 32'd0, last: 1'b1};
                  state_in = ST_IDLE;
               end
            end
         end
         ST_TICK: begin
            if (out_free) begin
               cmd.do_tick = 1'b1;
               if (sts.slot_fires) begin
                  out_valid_in = 1'b1;
                  out_in = '{kind: KIND_FIRED, handle: cur_handle, last: 1'b0};
               end
               if (sts.scan_last) begin
                  state_in = ST_OUT;
               end else begin
                  cmd.step_scan = 1'b1;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = '{kind: KIND_DONE, handle: 32'd0, last: 1'b1};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         next_after_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         next_after_ff <= next_after_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/software_timer_bank_unit.sv -----
// Top level of the software timer bank: controller plus slot datapath.
// Depends on stb_pkg, stb_if, stb_control, stb_datapath.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_if.valid/.ready  | opcode, timeout_ticks, periodic, target_handle
//  rsp     | out | rsp_if.valid/.ready  | kind, handle, last
//
// Every command first walks the slot table once after the accept cycle;
// rearm, disarm, delete and unused opcodes then reply from the decide step.
// A create that can proceed adds one walk per candidate handle tried (at
// least one), plus a decide step that writes the slot and replies. A tick
// walks the table a second time, one slot per cycle while the output
// register is free, then closes with tick done. Any step that loads the
// output register stalls while it is full. Reset is synchronous and clears
// the used and active bits and the handle seed.
`timescale 1ns / 1ps
`default_nettype none
module software_timer_bank_unit import stb_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   stb_if.sink req_if,
   stb_if.source rsp_if
);
   cmd_type cmd;
   sts_type sts;
   logic [31:0] cur_handle, new_handle;

   stb_control u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_if.valid), .req_ready(req_if.ready),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_data(rsp_if.data),
      .sts(sts), .cur_handle(cur_handle), .new_handle(new_handle), .cmd(cmd)
   );

   stb_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req_if.data), .cmd(cmd),
      .sts(sts), .cur_handle(cur_handle), .new_handle(new_handle)
   );

   a_one_apply: assert property (@(posedge clock) disable iff (reset)
      !(cmd.do_create && cmd.do_tick)) else $error("create during tick");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> !req_if.ready) else $error("ready while busy");
   a_create_nz: assert property (@(posedge clock) disable iff (reset)
      cmd.do_create |-> new_handle != 32'd0) else $error("zero handle");
endmodule
`default_nettype wire
